/* design/pie_pkg.sv */
// Shared types and constants for the power iteration block.
package pie_pkg;

  localparam int MaxOrder = 16;
  localparam int IdxW     = $clog2(MaxOrder);
  localparam int OrdW     = 5;
  localparam int MatW     = 16;
  localparam int VecW     = 32;
  localparam int EigW     = 31;
  localparam int CntW     = 16;
  localparam int AccW     = 56;
  localparam int MagW     = AccW - 1;
  localparam int QuoW     = 17;

  localparam logic [1:0] CmdLoadMat = 2'd0;
  localparam logic [1:0] CmdLoadVec = 2'd1;
  localparam logic [1:0] CmdStart   = 2'd2;

  localparam logic [1:0] RegOrder = 2'd0;
  localparam logic [1:0] RegTol   = 2'd1;
  localparam logic [1:0] RegLimit = 2'd2;

  localparam logic [1:0] StConv  = 2'd0;
  localparam logic [1:0] StLimit = 2'd1;
  localparam logic [1:0] StZero  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC_RD, S_MAC, S_ROW_END, S_DIV_RD, S_DIV_START, S_DIV,
    S_DIV_END, S_CMT_RD, S_DECIDE, S_OUT_RD, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_run;     // new run: clear iteration count
    logic clr_iter;    // new iteration: clear estimate and error
    logic clr_acc;     // clear row accumulator
    logic mac;         // accumulate one product
    logic row_done;    // store sum of current row
    logic div_load;    // load divider for current row
    logic div_step;    // one quotient bit
    logic div_done;    // write quotient, update error
    logic commit;      // copy next vector into current
    logic cnt_inc;     // bump iteration count
    logic set_zero;
    logic [1:0] status;
    logic set_status;
    logic emit;
    logic emit_last;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] ci;  // index read from current/next vectors
  } ctl_t;

  typedef struct packed {
    logic est_zero;
    logic converged;
    logic at_limit;
  } sts_t;

endpackage

/* design/pie_ram.sv */
// Generic single-write, single-read RAM with registered read.
module pie_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* design/pie_ctrl.sv */
// Controller state machine for the power iteration block.
module pie_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [pie_pkg::OrdW-1:0]  order,
  input  logic                      div_busy,
  input  pie_pkg::sts_t             sts,
  output pie_pkg::ctl_t             ctl,
  output logic                      busy
);
  localparam int IW = pie_pkg::IdxW;

  pie_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IW-1:0] last_idx;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    if (order == '0) last_idx = '0;
    else if (order >= pie_pkg::OrdW'(pie_pkg::MaxOrder)) last_idx = IW'(pie_pkg::MaxOrder - 1);
    else last_idx = IW'(order - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pie_pkg::S_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      status_r <= pie_pkg::StConv;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      status_r <= status_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    status_nxt = status_r;
    unique case (state_r)
      pie_pkg::S_IDLE: if (go) begin
        state_nxt = pie_pkg::S_MAC_RD; i_nxt = '0; j_nxt = '0;
      end
      pie_pkg::S_MAC_RD: state_nxt = pie_pkg::S_MAC;
      pie_pkg::S_MAC: begin
        if (j_r == last_idx) begin
          state_nxt = pie_pkg::S_ROW_END;
        end else begin
          j_nxt = j_r + 1'b1; state_nxt = pie_pkg::S_MAC_RD;
        end
      end
      pie_pkg::S_ROW_END: begin
        j_nxt = '0;
        if (i_r == last_idx) begin
          i_nxt = '0; state_nxt = pie_pkg::S_DIV_RD;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = pie_pkg::S_MAC_RD;
        end
      end
      pie_pkg::S_DIV_RD: state_nxt = pie_pkg::S_DIV_START;
      pie_pkg::S_DIV_START: begin
        if (sts.est_zero) begin
          status_nxt = pie_pkg::StZero; i_nxt = '0; state_nxt = pie_pkg::S_OUT_RD;
        end else begin
          state_nxt = pie_pkg::S_DIV;
        end
      end
      pie_pkg::S_DIV: if (!div_busy) state_nxt = pie_pkg::S_DIV_END;
      pie_pkg::S_DIV_END: begin
        if (i_r == last_idx) begin
          i_nxt = '0; state_nxt = pie_pkg::S_CMT_RD;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = pie_pkg::S_DIV_RD;
        end
      end
      pie_pkg::S_CMT_RD: state_nxt = pie_pkg::S_DECIDE;
      pie_pkg::S_DECIDE: begin
        // commit happens over this pass; reuse i as commit index
        if (i_r == last_idx) begin
          i_nxt = '0;
          if (sts.converged) begin
            status_nxt = pie_pkg::StConv; state_nxt = pie_pkg::S_OUT_RD;
          end else if (sts.at_limit) begin
            status_nxt = pie_pkg::StLimit; state_nxt = pie_pkg::S_OUT_RD;
          end else begin
            state_nxt = pie_pkg::S_MAC_RD;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      pie_pkg::S_OUT_RD: state_nxt = pie_pkg::S_OUT;
      pie_pkg::S_OUT: begin
        if (i_r == last_idx) begin
          i_nxt = '0; state_nxt = pie_pkg::S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = pie_pkg::S_OUT_RD;
        end
      end
      default: state_nxt = pie_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    ctl.i = i_r;
    ctl.j = j_r;
    ctl.ci = j_r;
    ctl.status = status_nxt;
    busy = (state_r != pie_pkg::S_IDLE);
    unique case (state_r)
      pie_pkg::S_IDLE: begin
        ctl.clr_run = go; ctl.clr_iter = go; ctl.clr_acc = go;
      end
      pie_pkg::S_MAC_RD: ctl.ci = j_r;
      pie_pkg::S_MAC: ctl.mac = 1'b1;
      pie_pkg::S_ROW_END: begin
        ctl.row_done = 1'b1; ctl.clr_acc = 1'b1;
        if (i_r == last_idx) ctl.cnt_inc = 1'b1;
        ctl.ci = '0;
      end
      pie_pkg::S_DIV_RD: ctl.ci = i_r;
      pie_pkg::S_DIV_START: begin
        ctl.ci = i_r;
        ctl.div_load = !sts.est_zero;
        ctl.set_zero = sts.est_zero;
        ctl.set_status = sts.est_zero;
      end
      pie_pkg::S_DIV: begin ctl.div_step = 1'b1; ctl.ci = i_r; end
      pie_pkg::S_DIV_END: begin ctl.div_done = 1'b1; ctl.ci = i_r; end
      pie_pkg::S_CMT_RD: ctl.ci = i_r;
      pie_pkg::S_DECIDE: begin
        // read ahead so the next commit finds its element ready
        ctl.commit = 1'b1; ctl.ci = i_r + 1'b1;
        if (i_r == last_idx) begin
          ctl.set_status = sts.converged || sts.at_limit;
          ctl.clr_iter = !(sts.converged || sts.at_limit);
          ctl.clr_acc = 1'b1;
        end
      end
      pie_pkg::S_OUT_RD: ctl.ci = i_r;
      pie_pkg::S_OUT: begin
        ctl.ci = i_r; ctl.emit = 1'b1; ctl.emit_last = (i_r == last_idx);
      end
      default: ;
    endcase
  end
endmodule

/* design/pie_dp.sv */
// Datapath: stores, multiply-accumulate, divider and result registers.
module pie_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld_mat,
  input  logic                        ld_vec,
  input  logic [pie_pkg::IdxW-1:0]    ld_row,
  input  logic [pie_pkg::IdxW-1:0]    ld_col,
  input  logic signed [pie_pkg::MatW-1:0] ld_mat_val,
  input  logic signed [pie_pkg::VecW-1:0] ld_vec_val,
  input  logic [pie_pkg::EigW-1:0]    tol,
  input  logic [pie_pkg::CntW-1:0]    limit,
  input  pie_pkg::ctl_t               ctl,
  output pie_pkg::sts_t               sts,
  output logic                        div_busy,
  output logic                        out_valid,
  output logic [pie_pkg::IdxW-1:0]    out_idx,
  output logic signed [pie_pkg::VecW-1:0] out_val,
  output logic [pie_pkg::EigW-1:0]    out_eig,
  output logic [pie_pkg::CntW-1:0]    out_iter,
  output logic [1:0]                  out_stat,
  output logic                        out_last
);
  localparam int IW = pie_pkg::IdxW;
  localparam int AW = pie_pkg::AccW;
  localparam int MW = pie_pkg::MagW;
  localparam int VW = pie_pkg::VecW;
  localparam int QW = pie_pkg::QuoW;

  // matrix store
  logic signed [pie_pkg::MatW-1:0] m_rd;
  pie_ram #(.Width(pie_pkg::MatW), .Depth(pie_pkg::MaxOrder * pie_pkg::MaxOrder)) u_mat (
    .clk, .we(ld_mat), .waddr({ld_row, ld_col}), .wdata(ld_mat_val),
    .raddr({ctl.i, ctl.j}), .rdata(m_rd)
  );

  // current vector: loaded from port or committed from next
  logic signed [VW-1:0] c_rd, n_rd;
  logic              c_we;
  logic [IW-1:0]     c_wa;
  logic [VW-1:0]     c_wd;
  assign c_we = ld_vec || ctl.commit;
  assign c_wa = ctl.commit ? ctl.i : ld_row;
  assign c_wd = ctl.commit ? n_rd : ld_vec_val;
  pie_ram #(.Width(VW), .Depth(pie_pkg::MaxOrder)) u_cur (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(ctl.ci), .rdata(c_rd)
  );

  // next vector
  logic          n_we;
  logic [VW-1:0] n_wd;
  logic [IW-1:0] n_ra;
  pie_ram #(.Width(VW), .Depth(pie_pkg::MaxOrder)) u_nxt (
    .clk, .we(n_we), .waddr(ctl.i), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
  );

  // row sums
  logic signed [AW-1:0] s_rd;
  logic signed [AW-1:0] acc_r, acc_nxt;
  pie_ram #(.Width(AW), .Depth(pie_pkg::MaxOrder)) u_sum (
    .clk, .we(ctl.row_done), .waddr(ctl.i), .wdata(acc_r), .raddr(ctl.ci), .rdata(s_rd)
  );

  logic signed [VW+pie_pkg::MatW-1:0] prod;
  assign prod = m_rd * c_rd;

  logic [MW-1:0] est_r, est_nxt, acc_mag;
  logic [VW:0]   err_r, err_nxt;
  logic [pie_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic zero_r, zero_nxt;
  logic [1:0] stat_r, stat_nxt;

  assign acc_mag = acc_r[AW-1] ? MW'(-acc_r) : MW'(acc_r);

  // restoring divider: |s| / est in Q16.16
  logic [MW:0]   rem_r, rem_nxt, rem_sh;
  logic [QW-1:0] q_r, q_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic          neg_r, neg_nxt;
  logic [MW-1:0] s_mag;
  assign s_mag = s_rd[AW-1] ? MW'(-s_rd) : MW'(s_rd);
  assign rem_sh = {rem_r[MW-1:0], 1'b0};
  assign div_busy = (dcnt_r != '0);

  logic signed [VW-1:0] quo;
  logic signed [VW:0]   diff;
  logic [VW:0]          dmag;
  assign quo  = neg_r ? -VW'(q_r) : VW'(q_r);
  assign diff = {quo[VW-1], quo} - {c_rd[VW-1], c_rd};
  assign dmag = diff[VW] ? -diff : diff;

  assign n_we = ctl.div_done || ctl.set_zero;
  assign n_wd = ctl.set_zero ? '0 : quo;
  assign n_ra = ctl.ci;

  always_comb begin
    acc_nxt  = acc_r;
    est_nxt  = est_r;
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    stat_nxt = stat_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dcnt_nxt = dcnt_r;
    neg_nxt  = neg_r;
    if (ctl.clr_run) begin cnt_nxt = '0; zero_nxt = 1'b0; end
    if (ctl.clr_acc) acc_nxt = '0;
    if (ctl.mac) acc_nxt = acc_r + AW'(prod);
    if (ctl.row_done && acc_mag > est_r) est_nxt = acc_mag;
    if (ctl.clr_iter) begin est_nxt = '0; err_nxt = '0; end
    if (ctl.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    if (ctl.div_load) begin
      neg_nxt  = s_rd[AW-1];
      dcnt_nxt = 5'd16;
      if ({1'b0, s_mag} >= {1'b0, est_r}) begin
        q_nxt = QW'(1); rem_nxt = {1'b0, s_mag - est_r};
      end else begin
        q_nxt = '0; rem_nxt = {1'b0, s_mag};
      end
    end
    if (ctl.div_step && div_busy) begin
      dcnt_nxt = dcnt_r - 1'b1;
      if (rem_sh >= {1'b0, est_r}) begin
        rem_nxt = rem_sh - {1'b0, est_r}; q_nxt = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh; q_nxt = {q_r[QW-2:0], 1'b0};
      end
    end
    if (ctl.div_done && dmag > err_r) err_nxt = dmag;
    if (ctl.set_zero) zero_nxt = 1'b1;
    if (ctl.set_status) stat_nxt = ctl.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dcnt_r <= '0;
      zero_r <= 1'b0;
      stat_r <= pie_pkg::StConv;
      out_valid <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      dcnt_r <= dcnt_nxt;
      zero_r <= zero_nxt;
      stat_r <= stat_nxt;
      out_valid <= ctl.emit;
    end
    acc_r <= acc_nxt;
    est_r <= est_nxt;
    err_r <= err_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    if (ctl.emit) begin
      out_idx  <= ctl.i;
      out_val  <= zero_r ? '0 : n_rd;
      out_eig  <= zero_r ? '0 :
                  (est_r > MW'({pie_pkg::EigW{1'b1}}) ? '1 : pie_pkg::EigW'(est_r));
      out_iter <= cnt_r;
      out_stat <= stat_r;
      out_last <= ctl.emit_last;
    end
  end

  assign sts.est_zero  = (est_r == '0);
  assign sts.converged = (err_r <= (VW+1)'(tol));
  assign sts.at_limit  = (cnt_r >= ((limit == '0) ? pie_pkg::CntW'(1) : limit));
endmodule

/* design/power_iteration_eigen.sv */
// Top level of the power iteration eigenvalue block.
// Usage: configure order, tolerance and iteration_limit through the cfg_ write port
// while the block is idle. Each command is a transfer on start when busy is low.
// Load commands (matrix entry, start vector entry) give no result and leave busy low,
// so loads can follow at one per cycle. With n the order in use, a start command runs
// iterations of: matrix times vector, each multiply-accumulate being a memory read then
// an accumulate, plus a row-end step per row; then a serial divider normalizes each
// element (read, load, divide, write), and a commit pass copies the new vector.
// A zero estimate, found once the product is done, ends the run before the divide.
// The run ends on convergence, at the iteration limit, or on a zero estimate.
// Results then leave as n transfers, each after a memory read step and each marked
// by out_valid for one cycle; out_last marks the final element. Busy drops in the
// cycle in which the last result is on the ports, so the next command can be
// accepted at the edge that ends it. The receiver cannot stall.
// Reset clears the controller and restores register defaults; the matrix and
// vector memories keep no reset value and must be loaded before a start.
module power_iteration_eigen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_column,
  input  logic signed [15:0] in_matrix_value,
  input  logic signed [31:0] in_vector_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_element_index,
  output logic signed [31:0] out_element_value,
  output logic [30:0] out_eigenvalue,
  output logic [15:0] out_iterations,
  output logic [1:0]  out_status,
  output logic        out_last
);
  logic [pie_pkg::OrdW-1:0] order_r;
  logic [pie_pkg::EigW-1:0] tol_r;
  logic [pie_pkg::CntW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= pie_pkg::OrdW'(4);
      tol_r   <= pie_pkg::EigW'(66);
      limit_r <= pie_pkg::CntW'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pie_pkg::RegOrder: order_r <= cfg_data[pie_pkg::OrdW-1:0];
        pie_pkg::RegTol:   tol_r   <= cfg_data;
        pie_pkg::RegLimit: limit_r <= cfg_data[pie_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  logic acc_in;
  assign acc_in = start && !busy;

  pie_pkg::ctl_t ctl;
  pie_pkg::sts_t sts;
  logic div_busy;

  pie_ctrl u_ctrl (
    .clk, .rst_n,
    .go(acc_in && (in_command == pie_pkg::CmdStart)),
    .order(order_r), .div_busy, .sts, .ctl, .busy
  );

  pie_dp u_dp (
    .clk, .rst_n,
    .ld_mat(acc_in && (in_command == pie_pkg::CmdLoadMat)),
    .ld_vec(acc_in && (in_command == pie_pkg::CmdLoadVec)),
    .ld_row(in_row), .ld_col(in_column),
    .ld_mat_val(in_matrix_value), .ld_vec_val(in_vector_value),
    .tol(tol_r), .limit(limit_r), .ctl, .sts, .div_busy,
    .out_valid, .out_idx(out_element_index), .out_val(out_element_value),
    .out_eig(out_eigenvalue), .out_iter(out_iterations),
    .out_stat(out_status), .out_last
  );
endmodule
